// ===== sv/idasc_pkg.sv =====
// ----------------------------------------------------------------------------
// idasc_pkg
// Shared constants and types for the decimal ASCII printer.
// ----------------------------------------------------------------------------
package idasc_pkg;

  localparam int unsigned DIGIT_W = 4;

  // double-dabble correction: digits of five or more get three added
  localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ       = 4'd3;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // control broadcast to every digit cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/idasc_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// idasc_bcd_cell
// One BCD digit of the shift-add-3 chain: corrects, then shifts one bit in
// from the lower neighbour and hands its top bit to the upper neighbour.
// ----------------------------------------------------------------------------
module idasc_bcd_cell (
  input  logic                             clk_i,
  input  idasc_pkg::cell_ctrl_t            ctrl_i,
  input  logic                             carry_i,
  output logic                             carry_o,
  output logic [idasc_pkg::DIGIT_W-1:0]    digit_o
);

  logic [idasc_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic [idasc_pkg::DIGIT_W-1:0] adj;

  assign adj = (digit_q >= idasc_pkg::BCD_ADJ_LIMIT) ? (digit_q + idasc_pkg::BCD_ADJ)
                                                     : digit_q;
  // carry depends on this cell only, so the chain has no ripple path
  assign carry_o = adj[idasc_pkg::DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[idasc_pkg::DIGIT_W-2:0], carry_i};
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

// ===== sv/int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Prints an integer as decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Input channel: value_bits_i and treat_as_signed_i, transferred when
// in_valid_i is high and in_stall_o is low. With treat_as_signed_i set and the
// top bit set, '-' is sent first and then the magnitude.
// Output channel: ascii_char_o and is_last_o, transferred when out_valid_o is
// high and out_stall_i is low. Digits go most significant first with no
// leading zeros; zero prints as '0'. is_last_o marks the final character.
// Timing: the magnitude is shifted bit-serially through a row of BCD digit
// cells, one bit per cycle, in state ST_CONV; then ST_FIND locates the leading
// digit, then one character leaves per cycle while the receiver does not stall.
// in_stall_o stays high from the transfer in until the last character is
// loaded into the output register, so the next number is taken while that
// character still waits. A stalling receiver holds the output register and
// pauses emission. Reset empties the output register and returns the block
// to idle.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_bits_i,
  input  logic                   treat_as_signed_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             ascii_char_o,
  output logic                   is_last_o
);

  // decimal digits of 2^W - 1 is floor(W * log10 2) + 1
  localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned IDXW = $clog2(NDIG);
  localparam int unsigned CNTW = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] mag_q;
  logic [CNTW-1:0]        cnt_q;
  logic [IDXW-1:0]        idx_q;
  logic                   sign_q;
  logic                   out_valid_q;
  logic [7:0]             char_q;
  logic                   last_q;

  logic                   in_xfer;
  logic                   out_free;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag_d;
  logic [IDXW-1:0]        top_idx;
  logic [idasc_pkg::DIGIT_W-1:0] cur_digit;

  idasc_pkg::cell_ctrl_t         ctrl;
  logic [NDIG:0]                 carry;
  logic [idasc_pkg::DIGIT_W-1:0] digit [NDIG];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign neg   = treat_as_signed_i && value_bits_i[VALUE_WIDTH-1];
  assign mag_d = neg ? (~value_bits_i + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_bits_i;

  assign ctrl.clear = in_xfer;
  assign ctrl.shift = (state_q == ST_CONV);
  assign carry[0]   = mag_q[VALUE_WIDTH-1];

  for (genvar g = 0; g < NDIG; g++) begin : g_cell
    idasc_bcd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .carry_i (carry[g]),
      .carry_o (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  // highest non-zero digit; zero when the whole number is zero
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (digit[k] != '0) begin
        top_idx = IDXW'(k);
      end
    end
  end

  assign cur_digit = digit[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sign_q      <= 1'b0;
      mag_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // during emission the output register is refilled below instead
      if ((state_q != ST_EMIT) && out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            mag_q   <= mag_d;
            sign_q  <= neg;
            cnt_q   <= CNTW'(VALUE_WIDTH - 1);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
          if (cnt_q == '0) begin
            state_q <= ST_FIND;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_FIND: begin
          idx_q   <= top_idx;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (sign_q) begin
              char_q <= idasc_pkg::ASCII_MINUS;
              last_q <= 1'b0;
              sign_q <= 1'b0;
            end else begin
              char_q <= idasc_pkg::ASCII_ZERO + {4'b0000, cur_digit};
              last_q <= (idx_q == '0);
              if (idx_q == '0) begin
                state_q <= ST_IDLE;
              end else begin
                idx_q <= idx_q - 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign is_last_o    = last_q;

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_CONV)
    else $error("transfer in did not start conversion");

  a_find_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIND |=> state_q == ST_EMIT)
    else $error("leading digit search not followed by emission");

  a_pending_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_last_o) |-> state_q == ST_EMIT)
    else $error("non-final character without emission in progress");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ascii_char_o == idasc_pkg::ASCII_MINUS) ||
                    ((ascii_char_o >= idasc_pkg::ASCII_ZERO) &&
                     (ascii_char_o <= idasc_pkg::ASCII_NINE)))
    else $error("character outside sign and digits");

endmodule

// ===== tb/sv/tb_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii
// Self-checking testbench for the decimal ASCII printer.
// ----------------------------------------------------------------------------
// Numbers are queued up front, directed corner values first, then random
// values biased towards short texts, negatives and powers of ten. A driver
// presents them on the input channel and a monitor predicts the text of every
// accepted number. Each character that leaves is compared with the oldest
// predicted one. Sender gaps and receiver stalls are randomised in three
// phases, and a few numbers are held back until the output has fully drained.
// ----------------------------------------------------------------------------
module tb_int_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned N_RANDOM    = 242;
  localparam int unsigned SEND_IDLE_PCT [3] = '{26, 52, 0};
  localparam int unsigned RECV_STALL_PCT[3] = '{52, 26, 0};

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic                   as_signed;
    logic                   drain_first;
    int unsigned            phase;
  } number_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [VALUE_WIDTH-1:0] value_bits_i;
  logic                   treat_as_signed_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [7:0]             ascii_char_o;
  logic                   is_last_o;

  number_t     numbers_to_send[$];
  text_char_t  expected_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned cur_phase      = 0;
  bit          number_taken   = 1'b0;

  int_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .value_bits_i     (value_bits_i),
    .treat_as_signed_i(treat_as_signed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ascii_char_o     (ascii_char_o),
    .is_last_o        (is_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Decimal text of one number: optional '-', then digits of the magnitude.
  task automatic predict_decimal_text(input logic [VALUE_WIDTH-1:0] raw,
                                      input logic as_signed);
    logic [VALUE_WIDTH-1:0] mag;
    logic [7:0]             digits[$];
    text_char_t             c;
    mag = raw;
    if (as_signed && raw[VALUE_WIDTH-1]) begin
      c.ch   = idasc_pkg::ASCII_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
      mag = -raw;  // wraps for the most negative value, as the block does
    end
    do begin
      digits.push_front(idasc_pkg::ASCII_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    for (int i = 0; i < digits.size(); i++) begin
      c.ch   = digits[i];
      c.last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endtask

  task automatic add_number(input logic [VALUE_WIDTH-1:0] v, input logic sgn,
                            input logic drain);
    number_t n;
    n.value       = v;
    n.as_signed   = sgn;
    n.drain_first = drain;
    n.phase       = (numbers_to_send.size() < 100) ? 0 :
                    (numbers_to_send.size() < 180) ? 1 : 2;
    numbers_to_send.push_back(n);
  endtask

  // Driver: presents numbers at the falling edge and randomises the receiver.
  always @(negedge clk_i) begin
    number_t n;
    logic    nxt_valid;
    if (rst_ni) begin
      if (!in_valid_i || number_taken) begin
        nxt_valid = 1'b0;
        if (numbers_to_send.size() > 0) begin
          n = numbers_to_send[0];
          if (n.drain_first && expected_chars.size() != 0) begin
            nxt_valid = 1'b0;
          end else if ($urandom_range(0, 99) >= SEND_IDLE_PCT[n.phase]) begin
            void'(numbers_to_send.pop_front());
            nxt_valid = 1'b1;
            cur_phase = n.phase;
          end
        end
        in_valid_i <= nxt_valid;
        if (nxt_valid) begin
          value_bits_i      <= n.value;
          treat_as_signed_i <= n.as_signed;
        end
      end
      number_taken = 1'b0;
      out_stall_i <= ($urandom_range(0, 99) < RECV_STALL_PCT[cur_phase]);
    end
  end

  // Monitor: checks output transfers, predicts input transfers, watchdog.
  always @(posedge clk_i) begin
    text_char_t exp_c;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    ascii_char_o, is_last_o));
        end else begin
          exp_c = expected_chars.pop_front();
          if (ascii_char_o !== exp_c.ch)
            report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                      ascii_char_o, exp_c.ch));
          if (is_last_o !== exp_c.last)
            report_mismatch($sformatf("is_last %0b, expected %0b on char 0x%02h",
                                      is_last_o, exp_c.last, exp_c.ch));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        predict_decimal_text(value_bits_i, treat_as_signed_i);
        number_taken = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    logic [VALUE_WIDTH-1:0] v;
    logic                   sgn;
    longint unsigned        p10;
    in_valid_i        = 1'b0;
    value_bits_i      = '0;
    treat_as_signed_i = 1'b0;
    out_stall_i       = 1'b0;
    rst_ni            = 1'b0;

    // corner values
    add_number(32'd0,          1'b0, 1'b0);
    add_number(32'd0,          1'b1, 1'b0);
    add_number(32'd1,          1'b0, 1'b0);
    add_number(32'd9,          1'b1, 1'b0);
    add_number(32'd10,         1'b0, 1'b0);
    add_number(32'd99,         1'b1, 1'b0);
    add_number(32'd100,        1'b0, 1'b0);
    add_number(32'hFFFF_FFFF,  1'b0, 1'b0);
    add_number(32'hFFFF_FFFF,  1'b1, 1'b1);
    add_number(32'h8000_0000,  1'b1, 1'b0);
    add_number(32'h8000_0000,  1'b0, 1'b0);
    add_number(32'h7FFF_FFFF,  1'b1, 1'b0);
    add_number(32'h7FFF_FFFF,  1'b0, 1'b0);
    add_number(32'd1000000000, 1'b0, 1'b0);
    add_number(32'd999999999,  1'b1, 1'b0);
    add_number(32'd4000000000, 1'b0, 1'b0);
    add_number(-32'd10,        1'b1, 1'b0);
    add_number(32'h8000_0001,  1'b1, 1'b0);

    repeat (N_RANDOM) begin
      sgn = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0, 1: v = $urandom();
        2:    v = $urandom_range(0, 99);
        3:    v = $urandom_range(0, 999999);
        4: begin
          v   = -$urandom_range(1, 1000);
          sgn = ($urandom_range(0, 3) != 0);
        end
        default: begin
          p10 = 1;
          repeat ($urandom_range(0, 9)) p10 = p10 * 10;
          v = VALUE_WIDTH'(p10 - 1 + $urandom_range(0, 2));
        end
      endcase
      add_number(v, sgn, ($urandom_range(0, 39) == 0));
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (numbers_to_send.size() != 0 || in_valid_i || expected_chars.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
